### hdl/tth_pkg.sv
// ----------------------------------------------------------------------------
// tth_pkg: shared types and constants of the touch track history
// Holds the sequencer state type, the result record and fixed widths.
// ----------------------------------------------------------------------------
package tth_pkg;

  localparam int TIME_W  = 32;
  localparam int SPEED_W = 27;
  localparam int DIST_W  = 24;
  localparam int CNT_W   = 8;
  localparam int MIV_W   = 16;
  localparam logic [MIV_W-1:0] MIN_INTERVAL_RST = 16'd1000;
  localparam logic [19:0] USEC_PER_SEC = 20'd1000000;

  localparam logic MODE_ADD   = 1'b0;
  localparam logic MODE_CLEAR = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_HEAD,
    ST_DECIDE,
    ST_RD_PREV,
    ST_RD_OLD,
    ST_WALK,
    ST_WALK_END,
    ST_DIV_X,
    ST_DIV_Y,
    ST_SQ,
    ST_ROOT,
    ST_OUT
  } tth_state_t;

  // Result record handed to the output register
  typedef struct packed {
    logic                       accepted;
    logic                       moving;
    logic [CNT_W-1:0]           entry_count;
    logic signed [SPEED_W-1:0]  speed_x;
    logic signed [SPEED_W-1:0]  speed_y;
    logic [TIME_W-1:0]          gesture_time;
    logic [DIST_W-1:0]          gesture_distance;
  } tth_result_t;

endpackage

### hdl/tth_ram.sv
// ----------------------------------------------------------------------------
// tth_ram: generic single-port RAM
// One write or one read a cycle, read data registered.
// ----------------------------------------------------------------------------
module tth_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write or read the addressed entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata <= mem_r[addr];
  end

endmodule

### hdl/tth_alu.sv
// ----------------------------------------------------------------------------
// tth_alu: shared iterative divide and square-root unit
// Restoring divide of a 64-bit magnitude by a 32-bit one, or a bit-pair
// integer root of a 64-bit value, one step a cycle.
// ----------------------------------------------------------------------------
module tth_alu (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        is_root,
  input  logic [63:0] opa,
  input  logic [31:0] opb,
  output logic        done,
  output logic [63:0] result
);

  logic [63:0] quo_r, quo_nxt;
  logic [64:0] rem_r, rem_nxt;
  logic [31:0] root_r, root_nxt;
  logic [5:0]  step_r, step_nxt;
  logic        busy_r, busy_nxt;
  logic        root_r_md, root_md_nxt;
  logic [64:0] trial;
  logic [65:0] rtrial;
  logic [65:0] rshift;
  logic [63:0] quo_step;
  logic [64:0] rem_step;
  logic [31:0] root_step;
  logic        last_step;

  assign rshift = {rem_r[63:0], quo_r[63:62]};
  assign rtrial = rshift - {32'd0, root_r, 2'b01};
  assign trial  = {rem_r[63:0], quo_r[63]} - {33'd0, opb};

  // Work out one divide or root step
  always_comb begin
    quo_step  = quo_r;
    rem_step  = rem_r;
    root_step = root_r;
    if (root_r_md) begin
      quo_step = {quo_r[61:0], 2'b00};
      if (!rtrial[65]) begin
        rem_step  = rtrial[64:0];
        root_step = {root_r[30:0], 1'b1};
      end else begin
        rem_step  = rshift[64:0];
        root_step = {root_r[30:0], 1'b0};
      end
    end else begin
      if (!trial[64]) begin
        rem_step = trial;
        quo_step = {quo_r[62:0], 1'b1};
      end else begin
        rem_step = {rem_r[63:0], quo_r[63]};
        quo_step = {quo_r[62:0], 1'b0};
      end
    end
  end

  assign last_step = root_r_md ? (step_r == 6'd31) : (step_r == 6'd63);

  // Load new operands or advance one step
  always_comb begin
    quo_nxt     = quo_r;
    rem_nxt     = rem_r;
    root_nxt    = root_r;
    step_nxt    = step_r;
    busy_nxt    = busy_r;
    root_md_nxt = root_r_md;
    if (start) begin
      quo_nxt     = opa;
      rem_nxt     = '0;
      root_nxt    = '0;
      step_nxt    = '0;
      busy_nxt    = 1'b1;
      root_md_nxt = is_root;
    end else if (busy_r) begin
      quo_nxt  = quo_step;
      rem_nxt  = rem_step;
      root_nxt = root_step;
      busy_nxt = !last_step;
      step_nxt = step_r + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    quo_r     <= quo_nxt;
    rem_r     <= rem_nxt;
    root_r    <= root_nxt;
    step_r    <= step_nxt;
    root_r_md <= root_md_nxt;
  end

  assign done   = busy_r && last_step;
  assign result = root_r_md ? {32'd0, root_step} : quo_step;

endmodule

### hdl/touch_track_history.sv
// ----------------------------------------------------------------------------
// touch_track_history: history of one finger's touch samples
// Keeps a ring of samples and derives speed, gesture time and distance.
// ----------------------------------------------------------------------------
// Sequence: when two or more entries are held, an item is worked by one
//   memory read per held entry plus one, a 64-step divide per axis and a
//   32-step root; otherwise it is loaded without walk, divide or root.
// Throughput: one item at a time; the next item is taken the cycle after the
//   result is loaded into the output register, which waits while it is full.
// Reset: synchronous active-low rst_n empties the history, sets the minimum
//   interval to 1000 us; the sample memories are not cleared.
module touch_track_history #(
  parameter int DEPTH    = 128,
  parameter int POS_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // tdata fields from bit 0: pos_x[15:0], pos_y[31:16], time_us[63:32]
  input  logic [63:0] in_tdata,
  // tuser: mode
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // tdata fields from bit 0: moving[0], entry_count[8:1], speed_x[35:9],
  // speed_y[62:36], gesture_time[94:63], gesture_distance[118:95], zero fill
  output logic [119:0] out_tdata,
  // tuser: accepted
  output logic        out_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);
  import tth_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int FW = $clog2(DEPTH + 1);
  localparam logic [FW-1:0] DEPTH_F = FW'(DEPTH);

  tth_state_t state_r, state_nxt;

  logic [MIV_W-1:0]    miv_r;
  logic [POS_BITS-1:0] px_r, py_r;
  logic [TIME_W-1:0]   t_r;
  logic                mode_r;
  logic [AW-1:0]       head_r;
  logic [FW-1:0]       fill_r;
  logic signed [POS_BITS:0] dx_r, dy_r;
  logic [POS_BITS-1:0] hx_r, hy_r;
  logic [TIME_W-1:0]   ht_r, pt_r;
  logic                acc_r;
  logic [FW-1:0]       k_r;
  logic [31:0]         ax_r, ay_r;
  logic [63:0]         sq_r;
  logic signed [SPEED_W-1:0] sx_r, sy_r;
  logic [TIME_W-1:0]   gt_r;
  logic [DIST_W-1:0]   gd_r;
  tth_result_t         res_r;
  logic                ovalid_r;

  // RAM control
  logic                we;
  logic                we_t;
  logic [AW-1:0]       addr;
  logic [POS_BITS-1:0] rx, ry;
  logic [TIME_W-1:0]   rt;
  logic [TIME_W-1:0]   wt;

  tth_ram #(.WIDTH(POS_BITS), .DEPTH(DEPTH)) u_ram_x (
    .clk(clk), .we(we), .addr(addr), .wdata(px_r), .rdata(rx));
  tth_ram #(.WIDTH(POS_BITS), .DEPTH(DEPTH)) u_ram_y (
    .clk(clk), .we(we), .addr(addr), .wdata(py_r), .rdata(ry));
  tth_ram #(.WIDTH(TIME_W), .DEPTH(DEPTH)) u_ram_t (
    .clk(clk), .we(we | we_t), .addr(addr), .wdata(wt), .rdata(rt));

  // Shared divide / root unit
  logic        alu_start, alu_root, alu_done;
  logic [63:0] alu_a, alu_res;
  logic [31:0] alu_b;

  tth_alu u_alu (
    .clk(clk), .rst_n(rst_n), .start(alu_start), .is_root(alu_root),
    .opa(alu_a), .opb(alu_b), .done(alu_done), .result(alu_res));

  // Decision terms
  logic signed [POS_BITS+1:0] ddx, ddy;
  logic [TIME_W-1:0]   gap;
  logic                take, push;
  logic signed [TIME_W-1:0] dt_s;
  logic [TIME_W-1:0]   dt_mag;
  logic signed [POS_BITS:0] dsel;
  logic [POS_BITS:0]   dmag;
  logic [POS_BITS+19:0] mulp;
  logic [63:0]         num;
  logic                neg;
  logic [POS_BITS-1:0] ex, ey;
  logic [32:0]         sumx, sumy;
  logic                in_acc, out_acc;
  logic [AW-1:0]       head_inc;
  logic [FW-1:0]       fill_inc;
  logic signed [SPEED_W-1:0] spd;
  logic [63:0]         mulx;
  logic [FW:0]         walk_off;
  logic [31:0]         sq_op;
  logic [63:0]         sq_prod, sq_sum;

  assign in_acc   = in_tvalid && in_tready;
  assign out_acc  = out_tvalid && out_tready;
  assign head_inc = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + AW'(1);
  assign fill_inc = (fill_r == DEPTH_F) ? fill_r : fill_r + FW'(1);
  assign walk_off = (FW+1)'(head_r) - (FW+1)'(k_r);

  assign ddx  = $signed({2'b0, px_r}) - $signed({2'b0, rx});
  assign ddy  = $signed({2'b0, py_r}) - $signed({2'b0, ry});
  assign gap  = t_r - rt;
  assign take = !gap[TIME_W-1] && (gap >= {16'd0, miv_r});
  assign push = (fill_r > FW'(1) && (dx_r != 0 || dy_r != 0)) || ddx != 0 || ddy != 0;

  // X divide is launched at the end of the walk, Y divide as X finishes
  assign dt_s   = $signed(ht_r - pt_r);
  assign dt_mag = dt_s[TIME_W-1] ? -ht_r + pt_r : ht_r - pt_r;
  assign dsel   = (state_r == ST_WALK_END) ? dx_r : dy_r;
  assign dmag   = dsel[POS_BITS] ? (POS_BITS+1)'(-dsel) : (POS_BITS+1)'(dsel);
  assign mulp   = dmag * USEC_PER_SEC;
  assign mulx   = 64'(mulp);
  assign num    = mulx;
  assign neg    = ((state_r == ST_DIV_X) ? dx_r[POS_BITS] : dy_r[POS_BITS])
                  ^ dt_s[TIME_W-1];

  assign ex   = (rx >= hx_r) ? rx - hx_r : hx_r - rx;
  assign ey   = (ry >= hy_r) ? ry - hy_r : hy_r - ry;
  assign sumx = 33'(ax_r) + 33'(ex);
  assign sumy = 33'(ay_r) + 33'(ey);

  // One squarer, x sum while dividing y, y sum when the root starts
  assign sq_op   = (state_r == ST_SQ) ? ay_r : ax_r;
  assign sq_prod = 64'(sq_op) * 64'(sq_op);
  assign sq_sum  = sq_r + sq_prod;

  // Saturate a quotient magnitude to the speed range
  always_comb begin
    if (neg) begin
      spd = (alu_res > 64'd67108864) ? SPEED_W'(-67108864)
                                     : SPEED_W'(-$signed(alu_res[SPEED_W:0]));
    end else begin
      spd = (alu_res > 64'd67108863) ? SPEED_W'(67108863) : SPEED_W'(alu_res);
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:     if (in_acc) state_nxt = ST_RD_HEAD;
      ST_RD_HEAD:  state_nxt = ST_DECIDE;
      ST_DECIDE:   state_nxt = ST_RD_PREV;
      ST_RD_PREV:  state_nxt = ST_RD_OLD;
      ST_RD_OLD:   state_nxt = (fill_r > FW'(1)) ? ST_WALK : ST_OUT;
      ST_WALK:     if (k_r == fill_r) state_nxt = ST_WALK_END;
      ST_WALK_END: state_nxt = ST_DIV_X;
      ST_DIV_X:    if (alu_done) state_nxt = ST_DIV_Y;
      ST_DIV_Y:    if (alu_done) state_nxt = ST_SQ;
      ST_SQ:       state_nxt = ST_ROOT;
      ST_ROOT:     if (alu_done) state_nxt = ST_OUT;
      ST_OUT:      if (!ovalid_r || out_acc) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // Memory address and write enables
  always_comb begin
    we   = 1'b0;
    we_t = 1'b0;
    wt   = t_r;
    addr = head_r;
    unique case (state_r)
      ST_DECIDE: begin
        if (!mode_r && (fill_r == '0 || (take && push))) begin
          we   = 1'b1;
          addr = head_inc;
        end else if (!mode_r && take) begin
          we_t = 1'b1;
        end
      end
      ST_WALK: addr = walk_off[FW] ? AW'(walk_off + (FW+1)'(DEPTH)) : AW'(walk_off);
      default: addr = head_r;
    endcase
  end

  // Divide / root launch
  always_comb begin
    alu_start = 1'b0;
    alu_root  = 1'b0;
    alu_a     = num;
    alu_b     = dt_mag;
    unique case (state_r)
      ST_WALK_END: alu_start = 1'b1;
      ST_DIV_X:    alu_start = alu_done;
      ST_SQ: begin
        alu_start = 1'b1;
        alu_root  = 1'b1;
        alu_a     = sq_sum;
      end
      default: alu_start = 1'b0;
    endcase
  end

  // Sequencer datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      miv_r    <= MIN_INTERVAL_RST;
      head_r   <= '0;
      fill_r   <= '0;
      dx_r     <= '0;
      dy_r     <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) miv_r <= cfg_data;
      if (state_r == ST_OUT && (!ovalid_r || out_acc)) ovalid_r <= 1'b1;
      else if (out_acc) ovalid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            px_r   <= POS_BITS'(in_tdata[15:0]);
            py_r   <= POS_BITS'(in_tdata[31:16]);
            t_r    <= in_tdata[63:32];
            mode_r <= in_tuser;
          end
          acc_r <= 1'b0;
          sx_r  <= '0;
          sy_r  <= '0;
          gt_r  <= '0;
          gd_r  <= '0;
          ax_r  <= '0;
          ay_r  <= '0;
        end
        ST_DECIDE: begin
          if (mode_r == MODE_CLEAR) begin
            fill_r <= '0;
            head_r <= '0;
            dx_r   <= '0;
            dy_r   <= '0;
          end else if (fill_r == '0) begin
            head_r <= head_inc;
            fill_r <= fill_inc;
            dx_r   <= '0;
            dy_r   <= '0;
            acc_r  <= 1'b1;
          end else if (take) begin
            acc_r <= 1'b1;
            if (push) begin
              head_r <= head_inc;
              fill_r <= fill_inc;
              dx_r   <= (POS_BITS+1)'(ddx);
              dy_r   <= (POS_BITS+1)'(ddy);
            end
          end
        end
        ST_RD_PREV: begin
          k_r <= '0;
        end
        ST_RD_OLD: begin
          hx_r <= rx;
          hy_r <= ry;
          ht_r <= rt;
        end
        // Entry k-1 arrives while address k is issued
        ST_WALK: begin
          if (k_r == FW'(2)) begin
            pt_r <= rt;
          end
          if (k_r == fill_r) begin
            gt_r <= ht_r - rt;
          end
          k_r <= k_r + FW'(1);
          if (k_r != '0) begin
            ax_r <= sumx[32] || sumx[31] ? 32'h7FFF_FFFF : sumx[31:0];
            ay_r <= sumy[32] || sumy[31] ? 32'h7FFF_FFFF : sumy[31:0];
          end
        end
        ST_DIV_X: if (alu_done) sx_r <= (dt_mag == '0) ? '0 : spd;
        ST_DIV_Y: begin
          if (alu_done) sy_r <= (dt_mag == '0) ? '0 : spd;
          sq_r <= sq_prod;
        end
        ST_ROOT: begin
          if (alu_done) begin
            gd_r <= (alu_res > 64'hFF_FFFF) ? '1 : alu_res[DIST_W-1:0];
          end
        end
        ST_OUT: begin
          if (!ovalid_r || out_acc) begin
            res_r.accepted         <= acc_r;
            res_r.moving           <= (fill_r > FW'(1)) && (dx_r != 0 || dy_r != 0);
            res_r.entry_count      <= CNT_W'(fill_r);
            res_r.speed_x          <= sx_r;
            res_r.speed_y          <= sy_r;
            res_r.gesture_time     <= gt_r;
            res_r.gesture_distance <= gd_r;
          end
        end
        default: ;
      endcase
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = ovalid_r;
  assign out_tuser  = res_r.accepted;
  assign out_tdata  = {1'b0, res_r.gesture_distance, res_r.gesture_time,
                       res_r.speed_y, res_r.speed_x, res_r.entry_count,
                       res_r.moving};

  // Checks on sequencing
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready) else $error("item taken while busy");
  a_fill_max: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= DEPTH_F) else $error("fill count beyond depth");
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DECIDE && mode_r == MODE_CLEAR) |=> fill_r == '0)
    else $error("clear left entries");

endmodule

### dv/touch_track_history_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// touch_track_history_tb: self-checking bench for the touch track history
// Drives directed samples, clears and interval settings, then random touch
// tracks under random idling on both streams. Every result item is compared
// with its row's typed expectation or with a behavioural ring model kept here.
// ----------------------------------------------------------------------------
module touch_track_history_tb;
  import tth_pkg::*;

  typedef enum {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic        mode;
    logic [15:0] x;
    logic [15:0] y;
    logic [31:0] t;      // timestamp, or interval for a setting row
    bit          typed;  // expectation written out in the row
    logic        exp_acc;
    logic [7:0]  exp_cnt;
  } stim_row_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [63:0]  in_tdata;
  logic         in_tuser;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [119:0] out_tdata;
  logic         out_tuser;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [15:0]  cfg_data;

  // Model of the track
  logic [15:0]  trk_x [128];
  logic [15:0]  trk_y [128];
  logic [31:0]  trk_t [128];
  int           trk_dx;
  int           trk_dy;
  logic [6:0]   trk_head;
  int           trk_fill;
  logic [15:0]  trk_min_gap;

  tth_result_t  pending_results[$];
  int           errors = 0;
  int           recv_stall = 0;
  int           recv_seen = 0;
  int           recv_count = 0;
  bit           quiet;
  stim_row_t    directed[$];

  touch_track_history dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Limit on the whole run
  initial begin
    #80ms;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic longint track_speed(int d, int dt);
    longint s;
    if (dt == 0) return 0;
    s = (longint'(d) * 1000000) / longint'(dt);
    if (s > 67108863) s = 67108863;
    if (s < -67108864) s = -67108864;
    return s;
  endfunction

  function automatic longint unsigned int_root(longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Apply one sample or clear to the model and return the result it gives
  function automatic tth_result_t track_update(logic mode, logic [15:0] x, logic [15:0] y,
                                               logic [31:0] t);
    tth_result_t r;
    int ddx, ddy, gap, dt;
    logic [6:0] prev, oldest, s;
    longint unsigned ax, ay, root;
    longint sp;
    r = '0;
    if (mode == MODE_CLEAR) begin
      trk_fill = 0;
      trk_head = '0;
      trk_dx = 0;
      trk_dy = 0;
    end else if (trk_fill == 0) begin
      trk_head = trk_head + 7'd1;
      trk_x[trk_head] = x;
      trk_y[trk_head] = y;
      trk_t[trk_head] = t;
      trk_fill = 1;
      trk_dx = 0;
      trk_dy = 0;
      r.accepted = 1'b1;
    end else begin
      ddx = int'(x) - int'(trk_x[trk_head]);
      ddy = int'(y) - int'(trk_y[trk_head]);
      gap = $signed(t - trk_t[trk_head]);
      if (longint'(gap) >= longint'(trk_min_gap)) begin
        if ((trk_fill > 1 && (trk_dx != 0 || trk_dy != 0)) || ddx != 0 || ddy != 0) begin
          trk_head = trk_head + 7'd1;
          trk_x[trk_head] = x;
          trk_y[trk_head] = y;
          trk_t[trk_head] = t;
          if (trk_fill < 128) trk_fill++;
          trk_dx = ddx;
          trk_dy = ddy;
        end else begin
          trk_t[trk_head] = t;
        end
        r.accepted = 1'b1;
      end
    end
    r.entry_count = trk_fill[7:0];
    if (trk_fill > 1) begin
      prev = trk_head - 7'd1;
      oldest = trk_head - 7'(trk_fill - 1);
      dt = $signed(trk_t[trk_head] - trk_t[prev]);
      r.moving = (trk_dx != 0 || trk_dy != 0);
      sp = track_speed(trk_dx, dt);
      r.speed_x = sp[SPEED_W-1:0];
      sp = track_speed(trk_dy, dt);
      r.speed_y = sp[SPEED_W-1:0];
      r.gesture_time = trk_t[trk_head] - trk_t[oldest];
      ax = 0;
      ay = 0;
      for (int k = 0; k < trk_fill; k++) begin
        s = trk_head - 7'(k);
        ax += (trk_x[s] >= trk_x[trk_head]) ? trk_x[s] - trk_x[trk_head]
                                             : trk_x[trk_head] - trk_x[s];
        ay += (trk_y[s] >= trk_y[trk_head]) ? trk_y[s] - trk_y[trk_head]
                                             : trk_y[trk_head] - trk_y[s];
      end
      if (ax > 64'h7FFFFFFF) ax = 64'h7FFFFFFF;
      if (ay > 64'h7FFFFFFF) ay = 64'h7FFFFFFF;
      root = int_root(ax * ax + ay * ay);
      if (root > 64'hFFFFFF) root = 64'hFFFFFF;
      r.gesture_distance = root[DIST_W-1:0];
    end
    return r;
  endfunction

  function automatic int draw_gap();
    return quiet ? 0 : $urandom_range(0, 10);
  endfunction

  // Offer one item and record its expected result once taken
  task automatic send_item(logic mode, logic [15:0] x, logic [15:0] y, logic [31:0] t,
                           bit typed, logic exp_acc, logic [7:0] exp_cnt);
    int gap;
    tth_result_t r;
    gap = draw_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {t, y, x};
    do @(posedge clk); while (!in_tready);
    r = track_update(mode, x, y, t);
    if (typed) begin
      r = '0;
      r.accepted = exp_acc;
      r.entry_count = exp_cnt;
    end
    pending_results.push_back(r);
  endtask

  // Hold off until all results are back, then write the interval
  task automatic write_interval(logic [15:0] v);
    @(negedge clk);
    in_tvalid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (500) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    trk_min_gap = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random touch tracks, with clears, noise and too-early samples mixed in
  task automatic random_phase(int n);
    int r;
    logic [15:0] x, y;
    logic [31:0] t, last_t;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) == 0) quiet = ~quiet;
      r = $urandom_range(0, 99);
      last_t = (trk_fill > 0) ? trk_t[trk_head] : $urandom;
      x = (trk_fill > 0) ? trk_x[trk_head] : 16'($urandom);
      y = (trk_fill > 0) ? trk_y[trk_head] : 16'($urandom);
      if (r < 3) begin
        send_item(MODE_CLEAR, 16'($urandom), 16'($urandom), $urandom, 0, 0, 0);
      end else if (r < 9) begin
        send_item(MODE_ADD, 16'($urandom), 16'($urandom), $urandom, 0, 0, 0);
      end else if (r < 19) begin
        if (trk_min_gap > 0) t = last_t + $urandom_range(0, trk_min_gap - 1);
        else t = last_t - $urandom_range(1, 1000);
        send_item(MODE_ADD, x + 16'($urandom_range(0, 3)), y, t, 0, 0, 0);
      end else if (r < 32) begin
        t = last_t + trk_min_gap + $urandom_range(0, 3000);
        send_item(MODE_ADD, x, y, t, 0, 0, 0);
      end else begin
        t = last_t + trk_min_gap + $urandom_range(0, 5000);
        x = x + 16'($urandom_range(0, 600)) - 16'd300;
        y = y + 16'($urandom_range(0, 600)) - 16'd300;
        send_item(MODE_ADD, x, y, t, 0, 0, 0);
      end
    end
  endtask

  // Stimulus
  initial begin
    stim_row_t row;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = MODE_ADD;
    cfg_valid = 1'b0;
    cfg_data = '0;
    quiet = 0;
    trk_fill = 0;
    trk_head = '0;
    trk_dx = 0;
    trk_dy = 0;
    trk_min_gap = MIN_INTERVAL_RST;

    // kind, mode, x, y, time or interval, typed, accepted, count
    directed = '{
      '{ROW_ITEM, MODE_ADD,   16'd0,     16'd0,     32'd100,        1, 1'b1, 8'd1},
      '{ROW_ITEM, MODE_ADD,   16'hFFFF,  16'hFFFF,  32'd1100,       0, 1'b0, 8'd0},
      '{ROW_ITEM, MODE_ADD,   16'hFFFF,  16'hFFFF,  32'd1500,       0, 1'b0, 8'd0},
      '{ROW_ITEM, MODE_ADD,   16'hFFFF,  16'hFFFF,  32'd2600,       0, 1'b0, 8'd0},
      '{ROW_ITEM, MODE_ADD,   16'hFFFF,  16'hFFFF,  32'd4000,       0, 1'b0, 8'd0},
      '{ROW_ITEM, MODE_ADD,   16'd0,     16'hFFFF,  32'hFFFFFF00,   0, 1'b0, 8'd0},
      '{ROW_ITEM, MODE_ADD,   16'd0,     16'hFFFF,  32'h80000F9F,   0, 1'b0, 8'd0},
      '{ROW_ITEM, MODE_CLEAR, 16'hFFFF,  16'hFFFF,  32'hFFFFFFFF,   1, 1'b0, 8'd0},
      '{ROW_ITEM, MODE_ADD,   16'd1234,  16'd4321,  32'hFFFFFFF0,   1, 1'b1, 8'd1},
      '{ROW_ITEM, MODE_ADD,   16'd1234,  16'd4322,  32'h00000400,   0, 1'b0, 8'd0},
      '{ROW_CFG,  MODE_ADD,   16'd0,     16'd0,     32'd0,          0, 1'b0, 8'd0},
      '{ROW_ITEM, MODE_ADD,   16'd0,     16'd0,     32'h00000500,   0, 1'b0, 8'd0},
      '{ROW_ITEM, MODE_ADD,   16'hFFFF,  16'd0,     32'h00000500,   0, 1'b0, 8'd0},
      '{ROW_ITEM, MODE_ADD,   16'd0,     16'hFFFF,  32'h00000501,   0, 1'b0, 8'd0},
      '{ROW_ITEM, MODE_ADD,   16'd0,     16'hFFFF,  32'h00000501,   0, 1'b0, 8'd0},
      '{ROW_ITEM, MODE_CLEAR, 16'd0,     16'd0,     32'd0,          1, 1'b0, 8'd0}
    };

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Walk the directed table
    foreach (directed[i]) begin
      row = directed[i];
      if (row.kind == ROW_CFG) write_interval(row.t[15:0]);
      else send_item(row.mode, row.x, row.y, row.t, row.typed, row.exp_acc, row.exp_cnt);
    end

    // Random tracks under several interval settings
    random_phase(380);
    write_interval(16'hFFFF);
    random_phase(300);
    write_interval(16'($urandom_range(1, 5000)));
    random_phase(380);
    write_interval(16'd1);
    random_phase(380);
    write_interval(MIN_INTERVAL_RST);
    random_phase(400);

    @(negedge clk);
    in_tvalid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (500) @(posedge clk);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  // Receiver back-pressure, a fresh wait drawn after each result item
  always @(negedge clk) begin
    if (recv_count != recv_seen) begin
      recv_seen = recv_count;
      recv_stall = draw_gap();
    end
    if (recv_stall > 0) begin
      out_tready <= 1'b0;
      recv_stall = recv_stall - 1;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Compare each result item with the oldest expectation
  always @(posedge clk) begin
    tth_result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      recv_count++;
      got.accepted         = out_tuser;
      got.moving           = out_tdata[0];
      got.entry_count      = out_tdata[8:1];
      got.speed_x          = out_tdata[35:9];
      got.speed_y          = out_tdata[62:36];
      got.gesture_time     = out_tdata[94:63];
      got.gesture_distance = out_tdata[118:95];
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result item %p", $realtime, got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: result mismatch expected %p actual %p", $realtime, want, got);
        end
      end
    end
  end

endmodule
